// ----- rtl/pirl_pkg.sv -----
// shared types and constants of the per-id message rate limiter
package pirl_pkg;

  localparam int unsigned MsgIdW = 8;
  localparam int unsigned TimeW  = 16;
  localparam int unsigned GapW   = 17;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [GapW-1:0] GapReset = 17'd1000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LIMIT_ENABLED = 1'b0,
    CFG_MIN_GAP_MS    = 1'b1
  } cfg_idx_e;

  // one request word
  typedef struct packed {
    logic [MsgIdW-1:0] msg_id;
    logic              caller_streaming;
    logic              type_is_streaming;
    logic              paused;
    logic [TimeW-1:0]  now_ms;
    logic [TimeW-1:0]  sched_tick;
  } req_t;

  // one per-id table entry
  typedef struct packed {
    logic [TimeW-1:0] last_send_time;
    logic [TimeW-1:0] last_decision_tick;
    logic             last_decision;
    logic             known_non_streaming;
    logic             ever_sent;
  } entry_t;

  // outcome of one decision
  typedef struct packed {
    logic   allow;
    logic   wr_en;
    entry_t entry;
  } dec_t;

endpackage

// ----- rtl/pirl_req_if.sv -----
// request channel: valid/ready handshake with the request fields
interface pirl_req_if;
  logic                          valid;
  logic                          ready;
  logic [pirl_pkg::MsgIdW-1:0]   msg_id;
  logic                          caller_streaming;
  logic                          type_is_streaming;
  logic                          paused;
  logic [pirl_pkg::TimeW-1:0]    now_ms;
  logic [pirl_pkg::TimeW-1:0]    sched_tick;

  modport source (
    output valid, msg_id, caller_streaming, type_is_streaming, paused, now_ms, sched_tick,
    input  ready
  );
  modport sink (
    input  valid, msg_id, caller_streaming, type_is_streaming, paused, now_ms, sched_tick,
    output ready
  );
endinterface

// ----- rtl/pirl_rsp_if.sv -----
// response channel: valid/ready handshake with the allow bit
interface pirl_rsp_if;
  logic valid;
  logic ready;
  logic allow;

  modport source (
    output valid, allow,
    input  ready
  );
  modport sink (
    input  valid, allow,
    output ready
  );
endinterface

// ----- rtl/pirl_decide.sv -----
// decision logic: next table entry and allow bit from the current entry and request
module pirl_decide (
  input  pirl_pkg::req_t                req_i,
  input  pirl_pkg::entry_t              entry_i,
  input  logic                          limit_enabled_i,
  input  logic [pirl_pkg::GapW-1:0]     min_gap_ms_i,
  output pirl_pkg::dec_t                dec_o
);

  logic [pirl_pkg::TimeW-1:0] delta;
  logic                       gap_ok;

  assign delta  = req_i.now_ms - entry_i.last_send_time;
  assign gap_ok = {1'b0, delta} >= min_gap_ms_i;

  always_comb begin
    dec_o       = '0;
    dec_o.entry = entry_i;
    if (!limit_enabled_i && !req_i.paused) begin
      dec_o.allow = 1'b1;
    end else if (!entry_i.ever_sent && !req_i.caller_streaming &&
                 (entry_i.known_non_streaming || !req_i.type_is_streaming)) begin
      dec_o.allow                     = 1'b1;
      dec_o.wr_en                     = 1'b1;
      dec_o.entry.known_non_streaming = 1'b1;
    end else if (req_i.sched_tick == entry_i.last_decision_tick) begin
      // repeat within the tick reuses the stored decision
      dec_o.allow = entry_i.last_decision;
    end else begin
      dec_o.wr_en                    = 1'b1;
      dec_o.entry.last_decision_tick = req_i.sched_tick;
      dec_o.allow                    = !req_i.paused && gap_ok;
      dec_o.entry.last_decision      = dec_o.allow;
      if (dec_o.allow) begin
        dec_o.entry.last_send_time = req_i.now_ms;
        dec_o.entry.ever_sent      = 1'b1;
      end
    end
  end

endmodule

// ----- rtl/per_id_message_rate_limiter.sv -----
// per-id message rate limiter: one allow bit per request from a per-id state table
//
// req_i carries a message id with its flags, the ms time and the scheduler tick;
// rsp_o returns one allow word per request, in order. Both use valid/ready and a
// word moves at a rising edge with valid and ready high.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i while idle:
// index 0 is limit_enabled, index 1 is min_gap_ms (65536 means never again).
// For each request the state memory is read at the edge that
// accepts it, and the entry is updated and written back with the result
// registered once the output register is free. A new request is accepted
// only after the previous one has finished.
// The output register holds a finished word while rsp_o is stalled; a new
// request is accepted meanwhile, but its write-back waits until the output
// register is free, and req_i.ready stays low until then.
// Reset clears the configuration to its defaults and the per-entry valid bits,
// so every entry reads as zero until written; no clearing pass is needed.
// Message ids are folded modulo ID_COUNT.
module per_id_message_rate_limiter #(
  parameter int unsigned ID_COUNT = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pirl_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pirl_pkg::GapW-1:0]     cfg_wdata_i,
  pirl_req_if.sink                      req_i,
  pirl_rsp_if.source                    rsp_o
);

  localparam int unsigned IdxW    = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
  localparam int unsigned IdRange = 1 << pirl_pkg::MsgIdW;

  logic                        limit_enabled_q;
  logic [pirl_pkg::GapW-1:0]   min_gap_ms_q;
  logic                        busy_q;
  logic                        out_valid_q;
  logic                        out_allow_q;
  logic [IdxW-1:0]             idx_q;
  pirl_pkg::req_t              req_q;
  pirl_pkg::entry_t            rdata_q;
  logic [ID_COUNT-1:0]         valid_q;
  pirl_pkg::entry_t            mem [ID_COUNT];

  logic [IdxW-1:0]             fold_tbl [IdRange];
  logic [IdxW-1:0]             rd_idx;
  logic                        req_fire;
  logic                        done;
  pirl_pkg::entry_t            entry_cur;
  pirl_pkg::req_t              req_cur;
  pirl_pkg::dec_t              dec;

  // id folding table, constant per elaboration
  for (genvar g = 0; g < IdRange; g++) begin : g_fold
    assign fold_tbl[g] = IdxW'(g % ID_COUNT);
  end

  assign rd_idx      = fold_tbl[req_i.msg_id];
  assign req_i.ready = !busy_q;
  assign req_fire    = req_i.valid && !busy_q;
  assign done        = busy_q && (!out_valid_q || rsp_o.ready);
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.allow = out_allow_q;

  assign req_cur.msg_id            = req_i.msg_id;
  assign req_cur.caller_streaming  = req_i.caller_streaming;
  assign req_cur.type_is_streaming = req_i.type_is_streaming;
  assign req_cur.paused            = req_i.paused;
  assign req_cur.now_ms            = req_i.now_ms;
  assign req_cur.sched_tick        = req_i.sched_tick;

  // entries never written read as the cleared value
  assign entry_cur = valid_q[idx_q] ? rdata_q : '0;

  pirl_decide u_decide (
    .req_i           (req_q),
    .entry_i         (entry_cur),
    .limit_enabled_i (limit_enabled_q),
    .min_gap_ms_i    (min_gap_ms_q),
    .dec_o           (dec)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_enabled_q <= 1'b0;
      min_gap_ms_q    <= pirl_pkg::GapReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pirl_pkg::CFG_LIMIT_ENABLED: limit_enabled_q <= cfg_wdata_i[0];
        pirl_pkg::CFG_MIN_GAP_MS:    min_gap_ms_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
    end else begin
      if (req_fire) begin
        busy_q <= 1'b1;
      end else if (done) begin
        busy_q <= 1'b0;
      end
      if (done) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (done && dec.wr_en) begin
        valid_q[idx_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      req_q   <= req_cur;
      idx_q   <= rd_idx;
      rdata_q <= mem[rd_idx];
    end
    if (done) begin
      out_allow_q <= dec.allow;
    end
  end

  // state memory write port
  always_ff @(posedge clk_i) begin
    if (done && dec.wr_en) begin
      mem[idx_q] <= dec.entry;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> busy_q)
    else $error("accepted request did not enter the update cycle");

  a_rsp_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(busy_q))
    else $error("response appeared without a request in flight");

  a_write_marks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done && dec.wr_en |=> valid_q[$past(idx_q)])
    else $error("written entry not marked valid");

  a_pass_when_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done && !limit_enabled_q && !req_q.paused |-> dec.allow && !dec.wr_en)
    else $error("request refused or state changed with limiting off");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !done |=> busy_q)
    else $error("update cycle dropped before completion");
`endif

endmodule

// ----- tb/per_id_message_rate_limiter_tb.sv -----
// testbench of the per-id message rate limiter: directed and random requests against a local model
module per_id_message_rate_limiter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdCount = 256;
  localparam logic [pirl_pkg::GapW-1:0] GapNever = 17'h10000;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [pirl_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [pirl_pkg::GapW-1:0]    cfg_wdata_i;

  pirl_req_if req_ch ();
  pirl_rsp_if rsp_ch ();

  per_id_message_rate_limiter #(.ID_COUNT(IdCount)) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch)
  );

  always #5 clk_i = ~clk_i;

  // per-id rate state as the block should hold it
  bit [pirl_pkg::TimeW-1:0] sent_at      [IdCount];
  bit [pirl_pkg::TimeW-1:0] decided_tick [IdCount];
  bit                       decided_ok   [IdCount];
  bit                       seen_plain   [IdCount];
  bit                       has_sent     [IdCount];
  bit                       lim_on = 1'b0;
  bit [pirl_pkg::GapW-1:0]  gap_ms = pirl_pkg::GapReset;

  bit allow_due [$];
  int err_count = 0;
  int send_idle_pct;
  int recv_idle_pct;

  function automatic bit predict_allow(input pirl_pkg::req_t w);
    int unsigned              slot;
    bit [pirl_pkg::TimeW-1:0] since;
    bit                       ok;
    slot = w.msg_id % IdCount;
    if (!lim_on && !w.paused) begin
      ok = 1'b1;
    end else if (!has_sent[slot] && !w.caller_streaming &&
                 (seen_plain[slot] || !w.type_is_streaming)) begin
      seen_plain[slot] = 1'b1;
      ok = 1'b1;
    end else if (w.sched_tick == decided_tick[slot]) begin
      ok = decided_ok[slot];
    end else begin
      decided_tick[slot] = w.sched_tick;
      since = w.now_ms - sent_at[slot];
      ok = !w.paused && ({1'b0, since} >= gap_ms);
      if (ok) begin
        sent_at[slot]  = w.now_ms;
        has_sent[slot] = 1'b1;
      end
      decided_ok[slot] = ok;
    end
    return ok;
  endfunction

  task automatic flag_error(input string what);
    err_count++;
    $display("mismatch: %s", what);
  endtask

  // response side: random stalls, every accepted word checked in order
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (allow_due.size() == 0) begin
          flag_error($sformatf("allow %0b with no request pending", rsp_ch.allow));
        end else begin
          if (rsp_ch.allow !== allow_due[0])
            flag_error($sformatf("allow %0b, predicted %0b", rsp_ch.allow, allow_due[0]));
          allow_due.delete(0);
        end
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_req(input logic [pirl_pkg::MsgIdW-1:0] id, input bit strm,
                          input bit type_strm, input bit pause,
                          input logic [pirl_pkg::TimeW-1:0] ms,
                          input logic [pirl_pkg::TimeW-1:0] tick);
    pirl_pkg::req_t w;
    w.msg_id            = id;
    w.caller_streaming  = strm;
    w.type_is_streaming = type_strm;
    w.paused            = pause;
    w.now_ms            = ms;
    w.sched_tick        = tick;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid             <= 1'b1;
    req_ch.msg_id            <= w.msg_id;
    req_ch.caller_streaming  <= w.caller_streaming;
    req_ch.type_is_streaming <= w.type_is_streaming;
    req_ch.paused            <= w.paused;
    req_ch.now_ms            <= w.now_ms;
    req_ch.sched_tick        <= w.sched_tick;
    do @(posedge clk_i); while (!req_ch.ready);
    allow_due.push_back(predict_allow(w));
  endtask

  // every word produces a response, so an empty queue means the block is idle
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (allow_due.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input pirl_pkg::cfg_idx_e idx,
                           input logic [pirl_pkg::GapW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      pirl_pkg::CFG_LIMIT_ENABLED: lim_on = val[0];
      pirl_pkg::CFG_MIN_GAP_MS:    gap_ms = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic test_limit_off_passes();
    send_req(8'd0, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0);
    send_req(8'd128, 1'b1, 1'b1, 1'b0, 16'd4660, 16'd9);
    // limit off but paused: rate path, refused without looking at the gap
    send_req(8'd255, 1'b1, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF);
    // plain id passes even while paused
    send_req(8'd7, 1'b0, 1'b0, 1'b1, 16'd50, 16'd3);
  endtask

  task automatic test_first_tick_and_repeat();
    wait_idle();
    write_reg(pirl_pkg::CFG_LIMIT_ENABLED, pirl_pkg::GapW'(1));
    // tick equal to the cleared decision tick reuses the cleared refusal
    send_req(8'd3, 1'b1, 1'b1, 1'b0, 16'd2000, 16'd0);
    send_req(8'd3, 1'b1, 1'b0, 1'b0, 16'd1000, 16'd1);
    send_req(8'd3, 1'b1, 1'b0, 1'b0, 16'd1500, 16'd1);
    send_req(8'd3, 1'b1, 1'b0, 1'b0, 16'd1500, 16'd2);
    send_req(8'd3, 1'b1, 1'b0, 1'b0, 16'd2000, 16'd3);
  endtask

  task automatic test_non_streaming_first_send();
    send_req(8'd20, 1'b0, 1'b0, 1'b0, 16'd10, 16'd4);
    // already known as plain, type flag no longer matters
    send_req(8'd20, 1'b0, 1'b1, 1'b0, 16'd11, 16'd4);
    send_req(8'd21, 1'b0, 1'b1, 1'b0, 16'd0, 16'd5);
    send_req(8'd21, 1'b1, 1'b0, 1'b0, 16'd1000, 16'd6);
    // once sent, a plain request goes through the rate check
    send_req(8'd21, 1'b0, 1'b0, 1'b0, 16'd1001, 16'd7);
  endtask

  task automatic test_gap_extremes();
    wait_idle();
    write_reg(pirl_pkg::CFG_MIN_GAP_MS, '0);
    send_req(8'd40, 1'b1, 1'b1, 1'b0, 16'd123, 16'd9);
    send_req(8'd40, 1'b1, 1'b1, 1'b1, 16'd124, 16'd10);
    wait_idle();
    write_reg(pirl_pkg::CFG_MIN_GAP_MS, GapNever);
    send_req(8'd41, 1'b1, 1'b1, 1'b0, 16'hFFFF, 16'd11);
    wait_idle();
    write_reg(pirl_pkg::CFG_MIN_GAP_MS, 17'hFFFF);
    send_req(8'd42, 1'b1, 1'b1, 1'b0, 16'hFFFF, 16'd12);
  endtask

  // mostly a small pool of ids with ticks that repeat and times that creep past the gap
  task automatic test_random_traffic(input int per_set);
    logic [pirl_pkg::MsgIdW-1:0] pool [8];
    logic [pirl_pkg::GapW-1:0]   gap;
    logic [pirl_pkg::TimeW-1:0]  ms;
    logic [pirl_pkg::TimeW-1:0]  tick;
    logic [pirl_pkg::MsgIdW-1:0] id;
    int unsigned                 span;
    for (int s = 0; s < 6; s++) begin
      case (s)
        0:       gap = '0;
        1:       gap = 17'd1;
        2:       gap = pirl_pkg::GapReset;
        3:       gap = 17'hFFFF;
        4:       gap = GapNever;
        default: gap = pirl_pkg::GapW'($urandom_range(2, 5000));
      endcase
      wait_idle();
      write_reg(pirl_pkg::CFG_MIN_GAP_MS, gap);
      write_reg(pirl_pkg::CFG_LIMIT_ENABLED,
                (s == 5) ? pirl_pkg::GapW'($urandom_range(1)) : pirl_pkg::GapW'(1));
      if (gap == '0) span = 40;
      else if (gap > 8000) span = 24000;
      else span = gap / 3 + 1;
      foreach (pool[i]) pool[i] = pirl_pkg::MsgIdW'($urandom_range(255));
      ms   = pirl_pkg::TimeW'($urandom);
      tick = pirl_pkg::TimeW'($urandom);
      repeat (per_set) begin
        id = ($urandom_range(99) < 85) ? pool[$urandom_range(7)]
                                       : pirl_pkg::MsgIdW'($urandom);
        if ($urandom_range(99) >= 55) tick += pirl_pkg::TimeW'($urandom_range(1, 3));
        if ($urandom_range(99) < 3) ms = pirl_pkg::TimeW'($urandom);
        else ms += pirl_pkg::TimeW'($urandom_range(0, span));
        send_req(id, $urandom_range(99) < 65, $urandom_range(1) == 1,
                 $urandom_range(99) < 12, ms, tick);
      end
    end
  endtask

  initial begin
    rst_ni                   = 1'b0;
    cfg_we_i                 = 1'b0;
    cfg_idx_i                = pirl_pkg::CFG_LIMIT_ENABLED;
    cfg_wdata_i              = '0;
    req_ch.valid             = 1'b0;
    req_ch.msg_id            = '0;
    req_ch.caller_streaming  = 1'b0;
    req_ch.type_is_streaming = 1'b0;
    req_ch.paused            = 1'b0;
    req_ch.now_ms            = '0;
    req_ch.sched_tick        = '0;
    send_idle_pct            = 27;
    recv_idle_pct            = 88;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_limit_off_passes();
    test_first_tick_and_repeat();
    test_non_streaming_first_send();
    test_gap_extremes();
    test_random_traffic(108);
    send_idle_pct = 88;
    recv_idle_pct = 27;
    test_random_traffic(108);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(108);

    wait_idle();
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
